FILE: rtl/core/stlmf_pkg.sv
// ----------------------------------------------------------------------------
// stlmf_pkg
// Shared types, constants and glyph font for the scrolling text frame block.
// ----------------------------------------------------------------------------
package stlmf_pkg;

    localparam int MODULES     = 4;
    localparam int TEXT_DEPTH  = 128;              // power of two
    localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
    localparam int OUT_BYTES   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHAR_INDEX_W = 7;
    localparam int CHAR_W       = 8;
    localparam int ROW_ADDR_W   = 4;
    localparam int TLEN_W       = 8;
    localparam int START_W      = 8;
    localparam int SUM_W        = START_W + 1;
    localparam int GLYPHS       = 37;
    localparam int GLYPH_W      = 6;

    localparam logic [TLEN_W-1:0] TEXT_LENGTH_RST = 8'd28;
    localparam logic              MODE_TICK       = 1'b1;

    localparam logic [CHAR_W-1:0] CODE_A     = 8'd65;
    localparam logic [CHAR_W-1:0] CODE_Z     = 8'd90;
    localparam logic [CHAR_W-1:0] ALPHA_BIAS = 8'd54;
    localparam logic [CHAR_W-1:0] CODE_0     = 8'd48;
    localparam logic [CHAR_W-1:0] CODE_9     = 8'd57;
    localparam logic [CHAR_W-1:0] DIGIT_BIAS = 8'd47;

    typedef enum logic {
        CMD_LOAD,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [TEXT_AW-1:0]   addr;
        logic [CHAR_W-1:0]    code;
    } cmd_t;

    // column-major font, bit 0 of a column is the top row
    localparam logic [7:0] GLYPH_ROM [GLYPHS][8] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h3E,8'h7F,8'h71,8'h59,8'h4D,8'h7F,8'h3E,8'h00},
        '{8'h40,8'h42,8'h7F,8'h7F,8'h40,8'h40,8'h00,8'h00},
        '{8'h62,8'h73,8'h59,8'h49,8'h6F,8'h66,8'h00,8'h00},
        '{8'h22,8'h63,8'h49,8'h49,8'h7F,8'h36,8'h00,8'h00},
        '{8'h18,8'h1C,8'h16,8'h53,8'h7F,8'h7F,8'h50,8'h00},
        '{8'h27,8'h67,8'h45,8'h45,8'h7D,8'h39,8'h00,8'h00},
        '{8'h3C,8'h7E,8'h4B,8'h49,8'h79,8'h30,8'h00,8'h00},
        '{8'h03,8'h03,8'h71,8'h79,8'h0F,8'h07,8'h00,8'h00},
        '{8'h36,8'h7F,8'h49,8'h49,8'h7F,8'h36,8'h00,8'h00},
        '{8'h06,8'h4F,8'h49,8'h69,8'h3F,8'h1E,8'h00,8'h00},
        '{8'h7C,8'h7E,8'h13,8'h13,8'h7E,8'h7C,8'h00,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h49,8'h49,8'h7F,8'h36,8'h00},
        '{8'h1C,8'h3E,8'h63,8'h41,8'h41,8'h63,8'h22,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h41,8'h63,8'h3E,8'h1C,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h49,8'h5D,8'h41,8'h63,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h49,8'h1D,8'h01,8'h03,8'h00},
        '{8'h1C,8'h3E,8'h63,8'h41,8'h51,8'h73,8'h72,8'h00},
        '{8'h7F,8'h7F,8'h08,8'h08,8'h7F,8'h7F,8'h00,8'h00},
        '{8'h00,8'h41,8'h7F,8'h7F,8'h41,8'h00,8'h00,8'h00},
        '{8'h30,8'h70,8'h40,8'h41,8'h7F,8'h3F,8'h01,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h08,8'h1C,8'h77,8'h63,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h41,8'h40,8'h60,8'h70,8'h00},
        '{8'h7F,8'h7F,8'h0E,8'h1C,8'h0E,8'h7F,8'h7F,8'h00},
        '{8'h7F,8'h7F,8'h06,8'h0C,8'h18,8'h7F,8'h7F,8'h00},
        '{8'h1C,8'h3E,8'h63,8'h41,8'h63,8'h3E,8'h1C,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h49,8'h09,8'h0F,8'h06,8'h00},
        '{8'h1E,8'h3F,8'h21,8'h71,8'h7F,8'h5E,8'h00,8'h00},
        '{8'h41,8'h7F,8'h7F,8'h09,8'h19,8'h7F,8'h66,8'h00},
        '{8'h26,8'h6F,8'h4D,8'h59,8'h73,8'h32,8'h00,8'h00},
        '{8'h03,8'h41,8'h7F,8'h7F,8'h41,8'h03,8'h00,8'h00},
        '{8'h7F,8'h7F,8'h40,8'h40,8'h7F,8'h7F,8'h00,8'h00},
        '{8'h1F,8'h3F,8'h60,8'h60,8'h3F,8'h1F,8'h00,8'h00},
        '{8'h7F,8'h7F,8'h30,8'h18,8'h30,8'h7F,8'h7F,8'h00},
        '{8'h43,8'h67,8'h3C,8'h18,8'h3C,8'h67,8'h43,8'h00},
        '{8'h07,8'h4F,8'h78,8'h78,8'h4F,8'h07,8'h00,8'h00},
        '{8'h47,8'h63,8'h71,8'h59,8'h4D,8'h67,8'h73,8'h00}
    };

    // ASCII to font index; anything outside space, digits and capitals is blank
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] diff;
        diff = '0;
        if (code >= CODE_A && code <= CODE_Z)
        begin
            diff = code - ALPHA_BIAS;
        end
        else if (code >= CODE_0 && code <= CODE_9)
        begin
            diff = code - DIGIT_BIAS;
        end
        return diff[GLYPH_W-1:0];
    endfunction

    // one pixel row of a glyph, bit c is column c
    function automatic logic [7:0] glyph_row(input logic [GLYPH_W-1:0] g,
                                             input logic [2:0] r);
        logic [7:0] v;
        logic [7:0] col;
        v = '0;
        for (int c = 0; c < 8; c++)
        begin
            col  = (g < GLYPH_W'(GLYPHS)) ? GLYPH_ROM[g][c] : 8'h00;
            v[c] = col[3'd7 - r];
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/stlmf_if.sv
// ----------------------------------------------------------------------------
// stlmf_if
// Valid/ready channels of the scrolling text frame block.
// ----------------------------------------------------------------------------
interface stlmf_item_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [stlmf_pkg::CHAR_INDEX_W-1:0]  char_index;
    logic [stlmf_pkg::CHAR_W-1:0]        char_code;

    modport source (output valid, output mode, output char_index, output char_code,
                    input ready);
    modport sink   (input valid, input mode, input char_index, input char_code,
                    output ready);
endinterface

interface stlmf_result_if;
    logic                              valid;
    logic                              ready;
    logic [stlmf_pkg::ROW_ADDR_W-1:0]  row_address;
    logic [7:0]                        chain_byte_0;
    logic [7:0]                        chain_byte_1;
    logic [7:0]                        chain_byte_2;
    logic [7:0]                        chain_byte_3;
    logic                              last_row;

    modport source (output valid, output row_address, output chain_byte_0,
                    output chain_byte_1, output chain_byte_2, output chain_byte_3,
                    output last_row, input ready);
    modport sink   (input valid, input row_address, input chain_byte_0,
                    input chain_byte_1, input chain_byte_2, input chain_byte_3,
                    input last_row, output ready);
endinterface

interface stlmf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [stlmf_pkg::TLEN_W-1:0]  text_length;

    modport source (output valid, output text_length, input ready);
    modport sink   (input valid, input text_length, output ready);
endinterface

FILE: rtl/core/stlmf_ram.sv
// ----------------------------------------------------------------------------
// stlmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stlmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/stlmf_front.sv
// ----------------------------------------------------------------------------
// stlmf_front
// Accepts input words, classifies them as load or tick and queues them.
// ----------------------------------------------------------------------------
module stlmf_front (
    input  logic              clk,
    input  logic              rst_n,
    stlmf_item_if.sink        item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output stlmf_pkg::cmd_t   cmd
);
    import stlmf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push, pop;
    cmd_t             entry;
    logic [SUM_W-1:0] wide_index;

    assign item.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign cmd_valid  = (count_reg != '0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wide_index = SUM_W'(item.char_index);
        entry.kind = (item.mode == MODE_TICK) ? CMD_TICK : CMD_LOAD;
        entry.addr = wide_index[TEXT_AW-1:0];
        entry.code = item.char_code;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

FILE: rtl/core/stlmf_back.sv
// ----------------------------------------------------------------------------
// stlmf_back
// Executes queued words: stores text bytes, or fetches the character window
// and emits the eight row words of one frame, then advances the scroll.
// ----------------------------------------------------------------------------
module stlmf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  stlmf_pkg::cmd_t               cmd,
    input  logic [stlmf_pkg::TLEN_W-1:0]  text_length,
    output logic                          ram_wr_en,
    output logic [stlmf_pkg::TEXT_AW-1:0] ram_wr_addr,
    output logic [stlmf_pkg::CHAR_W-1:0]  ram_wr_data,
    output logic                          ram_rd_en,
    output logic [stlmf_pkg::TEXT_AW-1:0] ram_rd_addr,
    input  logic [stlmf_pkg::CHAR_W-1:0]  ram_rd_data,
    stlmf_result_if.source                result
);
    import stlmf_pkg::*;

    localparam int RD_W = $clog2(MODULES + 2);
    localparam int GI_W = (MODULES > 0) ? $clog2(MODULES + 1) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ROWS
    } state_t;

    state_t               state_reg,   state_next;
    logic [RD_W-1:0]      rd_cnt_reg,  rd_cnt_next;
    logic                 cap_vld_reg, cap_vld_next;
    logic [GI_W-1:0]      cap_idx_reg, cap_idx_next;
    logic [2:0]           row_reg,     row_next;
    logic [2:0]           offset_reg,  offset_next;
    logic [START_W-1:0]   start_reg,   start_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [7:0]           out_byte_reg [OUT_BYTES];
    logic [7:0]           out_byte_next [OUT_BYTES];
    logic                 out_last_reg, out_last_next;

    logic [GLYPH_W-1:0]   glyph_reg [MODULES + 1];
    logic [7:0]           row_byte [OUT_BYTES];
    logic [SUM_W-1:0]     rd_sum;
    logic [SUM_W-1:0]     start_inc;
    logic [TLEN_W-1:0]    limit;
    logic                 out_free;

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign ram_wr_en   = cmd_valid && cmd_ready && (cmd.kind == CMD_LOAD);
    assign ram_wr_addr = cmd.addr;
    assign ram_wr_data = cmd.code;
    assign rd_sum      = SUM_W'(start_reg) + SUM_W'(rd_cnt_reg);
    assign ram_rd_addr = rd_sum[TEXT_AW-1:0];
    assign out_free    = !out_valid_reg || result.ready;

    assign start_inc = SUM_W'(start_reg) + 1'b1;
    assign limit     = (text_length > TLEN_W'(MODULES)) ? text_length - TLEN_W'(MODULES)
                                                        : TLEN_W'(1);

    // module m sees glyphs m and m+1; output byte k carries module MODULES-1-k
    genvar k;
    generate
        for (k = 0; k < OUT_BYTES; k++)
        begin : g_byte
            if (k < MODULES)
            begin : g_used
                logic [15:0] window;
                logic [15:0] shifted;
                assign window  = {glyph_row(glyph_reg[MODULES - k], row_reg),
                                  glyph_row(glyph_reg[MODULES - 1 - k], row_reg)};
                assign shifted = window >> offset_reg;
                assign row_byte[k] = shifted[7:0];
            end
            else
            begin : g_unused
                assign row_byte[k] = 8'h00;
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        cap_vld_next   = 1'b0;
        cap_idx_next   = cap_idx_reg;
        row_next       = row_reg;
        offset_next    = offset_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_addr_next  = out_addr_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        ram_rd_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_TICK)
                begin
                    state_next  = ST_READ;
                    rd_cnt_next = '0;
                end
            end
            ST_READ:
            begin
                // one text read per cycle; a final step without a read lets the last read data be captured
                if (rd_cnt_reg == RD_W'(MODULES + 1))
                begin
                    state_next = ST_ROWS;
                    row_next   = '0;
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    cap_vld_next = 1'b1;
                    cap_idx_next = rd_cnt_reg[GI_W-1:0];
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
            end
            ST_ROWS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = ROW_ADDR_W'(row_reg) + 1'b1;
                    out_byte_next  = row_byte;
                    out_last_next  = (row_reg == 3'd7);
                    row_next       = row_reg + 1'b1;
                    if (row_reg == 3'd7)
                    begin
                        state_next  = ST_IDLE;
                        offset_next = offset_reg + 1'b1;
                        if (offset_reg == 3'd7)
                        begin
                            start_next = (start_inc >= SUM_W'(limit)) ? '0
                                                                      : start_inc[START_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            cap_vld_reg   <= 1'b0;
            cap_idx_reg   <= '0;
            row_reg       <= '0;
            offset_reg    <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_byte_reg  <= '{default: '0};
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            cap_vld_reg   <= cap_vld_next;
            cap_idx_reg   <= cap_idx_next;
            row_reg       <= row_next;
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            out_addr_reg  <= out_addr_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_vld_reg)
        begin
            glyph_reg[cap_idx_reg] <= glyph_of(ram_rd_data);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.row_address  = out_addr_reg;
    assign result.chain_byte_0 = out_byte_reg[0];
    assign result.chain_byte_1 = out_byte_reg[1];
    assign result.chain_byte_2 = out_byte_reg[2];
    assign result.chain_byte_3 = out_byte_reg[3];
    assign result.last_row     = out_last_reg;

endmodule

FILE: rtl/core/scroll_text_led_matrix_frame.sv
// ----------------------------------------------------------------------------
// scroll_text_led_matrix_frame
// Frame generator for a chain of 8x8 LED driver modules showing scrolling text.
// A load word writes one ASCII byte into the 128-entry text memory in the
// execution stage. A tick word is taken from the queue, reads MODULES+1
// characters through the single read port of the text memory, one per cycle,
// then emits eight row words through the output register, one per cycle while
// the sink is ready. A two-entry queue in front of the execution stage keeps
// taking words, until it is full, while a frame is being produced. text_length
// is written on the cfg channel, always ready, and must only change while the
// block is idle.
// Text positions that are read must have been loaded first.
// ----------------------------------------------------------------------------
module scroll_text_led_matrix_frame (
    input  logic            clk,
    input  logic            rst_n,
    stlmf_item_if.sink      item,
    stlmf_result_if.source  result,
    stlmf_cfg_if.sink       cfg
);
    import stlmf_pkg::*;

    logic [TLEN_W-1:0]  text_length_reg, text_length_next;
    logic               cmd_valid, cmd_ready;
    cmd_t               cmd;
    logic               ram_wr_en, ram_rd_en;
    logic [TEXT_AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [CHAR_W-1:0]  ram_wr_data, ram_rd_data;

    assign cfg.ready        = 1'b1;
    assign text_length_next = (cfg.valid && cfg.ready) ? cfg.text_length : text_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_length_reg <= TEXT_LENGTH_RST;
        end
        else
        begin
            text_length_reg <= text_length_next;
        end
    end

    stlmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    stlmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .text_length (text_length_reg),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .result      (result)
    );

    stlmf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule
